// ----- rtl/leb_pkg.sv -----
// shared types and constants of the line edit buffer
package leb_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 6;
    localparam int CHAR_W   = 8;

    localparam logic [POS_W-1:0]  LINE_MAX    = POS_W'(CAPACITY - 1);
    localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

    typedef enum logic [2:0] {
        CMD_CHAR  = 3'd0,
        CMD_LEFT  = 3'd1,
        CMD_RIGHT = 3'd2,
        CMD_BKSP  = 3'd3,
        CMD_DEL   = 3'd4,
        CMD_ENTER = 3'd5,
        CMD_OTHER = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_LEFT   = 3'd1,
        K_RIGHT  = 3'd2,
        K_BKSP   = 3'd3,
        K_DEL    = 3'd4,
        K_ENTER  = 3'd5,
        K_BEEP   = 3'd6
    } kind_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic shift_rd;
        logic shift_wr;
        logic finish;
        logic enter_rd;
        logic emit_edit;
        logic emit_char;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  enter_empty;
        logic  shift_done;
        logic  out_free;
        logic  enter_last;
    } dp_status_t;

endpackage

// ----- rtl/leb_if.sv -----
// key and result channel interfaces
interface leb_key_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] key_char;

    modport source (output valid, output command, output key_char, input ready);
    modport sink (input valid, input command, input key_char, output ready);
endinterface

interface leb_result_if;
    logic       valid;
    logic       ready;
    logic       beep;
    logic [5:0] cursor_pos;
    logic [5:0] line_length;
    logic       line_valid;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output beep, output cursor_pos, output line_length,
                    output line_valid, output out_char, output last, input ready);
    modport sink (input valid, input beep, input cursor_pos, input line_length,
                  input line_valid, input out_char, input last, output ready);
endinterface

// ----- rtl/leb_datapath.sv -----
// line memory, cursor and length, shift engine and result register
module leb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  leb_pkg::ctrl_cmd_t   cmd,
    output leb_pkg::dp_status_t  status,
    input  logic [2:0]           key_command,
    input  logic [7:0]           key_char,
    input  logic                 result_ready,
    output logic                 result_valid,
    output logic                 result_beep,
    output logic [5:0]           result_cursor_pos,
    output logic [5:0]           result_line_length,
    output logic                 result_line_valid,
    output logic [7:0]           result_out_char,
    output logic                 result_last
);
    import leb_pkg::*;

    logic [CHAR_W-1:0] line_mem [CAPACITY];

    logic [POS_W-1:0]  cursor_reg, cursor_next;
    logic [POS_W-1:0]  length_reg, length_next;
    logic              out_valid_reg, out_valid_next;

    cmd_t              cmd_reg;
    logic [CHAR_W-1:0] ch_reg;
    kind_t             kind_reg;
    kind_t             kind_dec;
    logic              beep_reg;
    logic [POS_W-1:0]  idx_reg;
    logic [POS_W-1:0]  n_reg;
    logic [CHAR_W-1:0] rdata_reg;

    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              is_ins;

    logic              ob_beep_reg;
    logic [POS_W-1:0]  ob_cursor_reg;
    logic [POS_W-1:0]  ob_length_reg;
    logic              ob_lv_reg;
    logic [CHAR_W-1:0] ob_char_reg;
    logic              ob_last_reg;

    // key classification
    always_comb
    begin
        kind_dec = K_BEEP;
        unique case (cmd_reg)
            CMD_CHAR:
            begin
                if (ch_reg == CH_NL || ch_reg == CH_CR)
                    kind_dec = K_ENTER;
                else if (ch_reg < CH_PRINT_LO || ch_reg > CH_PRINT_HI
                         || length_reg >= LINE_MAX)
                    kind_dec = K_BEEP;
                else
                    kind_dec = K_INSERT;
            end
            CMD_LEFT:  kind_dec = (cursor_reg != '0) ? K_LEFT : K_BEEP;
            CMD_RIGHT: kind_dec = (cursor_reg < length_reg) ? K_RIGHT : K_BEEP;
            CMD_BKSP:  kind_dec = (cursor_reg != '0) ? K_BKSP : K_BEEP;
            CMD_DEL:   kind_dec = (cursor_reg < length_reg) ? K_DEL : K_BEEP;
            CMD_ENTER: kind_dec = K_ENTER;
            default:   kind_dec = K_BEEP;
        endcase
    end

    assign is_ins = (kind_reg == K_INSERT);

    // insert moves the tail right, removals move it left
    always_comb
    begin
        rd_en   = cmd.shift_rd | cmd.enter_rd;
        rd_addr = (cmd.shift_rd && is_ins) ? idx_reg - POS_W'(1) : idx_reg;
        wr_en   = cmd.shift_wr | (cmd.finish & is_ins);
        if (cmd.shift_wr)
        begin
            wr_addr = is_ins ? idx_reg : idx_reg - POS_W'(1);
            wr_data = rdata_reg;
        end
        else
        begin
            wr_addr = cursor_reg;
            wr_data = ch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= line_mem[rd_addr];
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        length_next = length_reg;
        if (cmd.decode)
        begin
            case (kind_dec)
                K_LEFT:  cursor_next = cursor_reg - POS_W'(1);
                K_RIGHT: cursor_next = cursor_reg + POS_W'(1);
                K_ENTER:
                begin
                    cursor_next = '0;
                    length_next = '0;
                end
                default: ;
            endcase
        end
        if (cmd.finish)
        begin
            case (kind_reg)
                K_INSERT:
                begin
                    cursor_next = cursor_reg + POS_W'(1);
                    length_next = length_reg + POS_W'(1);
                end
                K_BKSP:
                begin
                    cursor_next = cursor_reg - POS_W'(1);
                    length_next = length_reg - POS_W'(1);
                end
                K_DEL:   length_next = length_reg - POS_W'(1);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cmd.emit_edit || cmd.emit_char)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= cmd_t'(key_command);
            ch_reg  <= key_char;
        end
        if (cmd.decode)
        begin
            kind_reg <= kind_dec;
            beep_reg <= (kind_dec == K_BEEP);
            n_reg    <= length_reg;
            case (kind_dec)
                K_INSERT: idx_reg <= length_reg;
                K_BKSP:   idx_reg <= cursor_reg;
                K_DEL:    idx_reg <= cursor_reg + POS_W'(1);
                default:  idx_reg <= '0;
            endcase
        end
        if (cmd.shift_wr)
            idx_reg <= is_ins ? idx_reg - POS_W'(1) : idx_reg + POS_W'(1);
        if (cmd.emit_char)
            idx_reg <= idx_reg + POS_W'(1);
        if (cmd.emit_edit)
        begin
            ob_beep_reg   <= beep_reg;
            ob_cursor_reg <= cursor_reg;
            ob_length_reg <= length_reg;
            ob_lv_reg     <= 1'b0;
            ob_char_reg   <= '0;
            ob_last_reg   <= 1'b1;
        end
        if (cmd.emit_char)
        begin
            ob_beep_reg   <= 1'b0;
            ob_cursor_reg <= cursor_reg;
            ob_length_reg <= length_reg;
            ob_lv_reg     <= 1'b1;
            ob_char_reg   <= rdata_reg;
            ob_last_reg   <= status.enter_last;
        end
    end

    assign status.kind        = kind_dec;
    assign status.enter_empty = (length_reg == '0);
    assign status.shift_done  = is_ins ? (idx_reg == cursor_reg) : (idx_reg == length_reg);
    assign status.out_free    = !out_valid_reg || result_ready;
    assign status.enter_last  = ((idx_reg + POS_W'(1)) == n_reg);

    assign result_valid       = out_valid_reg;
    assign result_beep        = ob_beep_reg;
    assign result_cursor_pos  = ob_cursor_reg;
    assign result_line_length = ob_length_reg;
    assign result_line_valid  = ob_lv_reg;
    assign result_out_char    = ob_char_reg;
    assign result_last        = ob_last_reg;

endmodule

// ----- rtl/leb_ctrl.sv -----
// sequencing state machine of the line edit buffer
module leb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_valid,
    output logic                 key_ready,
    input  leb_pkg::dp_status_t  status,
    output leb_pkg::ctrl_cmd_t   cmd
);
    import leb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_DECODE     = 7'b0000010,
        S_SHIFT_RD   = 7'b0000100,
        S_SHIFT_WR   = 7'b0001000,
        S_EMIT       = 7'b0010000,
        S_ENTER_RD   = 7'b0100000,
        S_ENTER_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        key_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                key_ready = 1'b1;
                if (key_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                unique case (status.kind) inside
                    K_LEFT, K_RIGHT, K_BEEP: state_next = S_EMIT;
                    K_INSERT, K_BKSP, K_DEL: state_next = S_SHIFT_RD;
                    K_ENTER: state_next = status.enter_empty ? S_EMIT : S_ENTER_RD;
                    default: state_next = S_EMIT;
                endcase
            end
            S_SHIFT_RD:
            begin
                if (status.shift_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_edit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ENTER_RD:
            begin
                cmd.enter_rd = 1'b1;
                state_next   = S_ENTER_EMIT;
            end
            S_ENTER_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    state_next    = status.enter_last ? S_IDLE : S_ENTER_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/line_edit_buffer_unit.sv -----
// line edit buffer top level: key beats in, result beats out
// cursor moves, beeps and empty enter: decode, then emit once the output register is free
// insert, backspace, delete: decode, a read and a write per tail character moved, then emit
// enter: a read state and an emit state per character beat, so the read port paces the beats
// the next key is taken the cycle after the last beat of a key enters the output register
// rst_n clears cursor, length, output valid and the controller; the line memory is not cleared
module line_edit_buffer_unit (
    input  logic         clk,
    input  logic         rst_n,
    leb_key_if.sink      key,
    leb_result_if.source result
);
    import leb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    leb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key.valid),
        .key_ready (key.ready),
        .status    (status),
        .cmd       (cmd)
    );

    leb_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .key_command        (key.command),
        .key_char           (key.key_char),
        .result_ready       (result.ready),
        .result_valid       (result.valid),
        .result_beep        (result.beep),
        .result_cursor_pos  (result.cursor_pos),
        .result_line_length (result.line_length),
        .result_line_valid  (result.line_valid),
        .result_out_char    (result.out_char),
        .result_last        (result.last)
    );

endmodule
